[design/interval_partition_assigner_top_macros.svh]
// Assertion macros shared by the interval partition assigner RTL.
`ifndef INTERVAL_PARTITION_ASSIGNER_TOP_MACROS_SVH
`define INTERVAL_PARTITION_ASSIGNER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define IPA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("interval partition assigner check failed");
// Checks that a condition is followed by a consequence in the next cycle.
`define IPA_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("interval partition assigner sequence check failed");
`else
`define IPA_ASSERT(label, clk, rst, prop)
`define IPA_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif
`endif

[design/ipa_pkg.sv]
// Types and constants shared by the interval partition assigner modules.
package ipa_pkg;

   localparam int REQ_TIME_BITS = 16;
   localparam int RSP_INDEX_BITS = 4;
   localparam int RSP_COUNT_BITS = 5;
   localparam int RSP_STATUS_BITS = 2;
   localparam int REQ_TDATA_BITS = 2 * REQ_TIME_BITS;
   localparam int RSP_TDATA_BITS = 16;

   localparam logic ACTION_SCHEDULE = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef enum logic [RSP_STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_ORDER = 2'd2
   } status_type;

   // Broadcast control that every cell of the resource row sees.
   typedef struct packed {
      logic schedule;
      logic clear;
      logic none_fit;
   } cell_ctrl_type;

endpackage

[design/ipa_cell.sv]
// One resource slot of the assigner row: end time, open flag and fit logic.
module ipa_cell
   import ipa_pkg::*;
#(
   parameter int TIME_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [TIME_BITS-1:0] start_time,
   input  logic [TIME_BITS-1:0] end_time,
   input  logic                 claim_in,
   input  logic                 prev_open,
   output logic                 claim_out,
   output logic                 take,
   output logic                 open
);

   logic [TIME_BITS-1:0] last_end_ff;
   logic [TIME_BITS-1:0] last_end_in;
   logic                 open_ff;
   logic                 open_in;
   logic                 fit;
   logic                 first_free;

   // A newer cell that fits has already claimed the activity when claim_in is set.
   assign fit        = open_ff && (last_end_ff <= start_time);
   assign first_free = !open_ff && prev_open;
   assign claim_out  = claim_in || fit;
   assign take       = ctrl.schedule && ((fit && !claim_in) || (first_free && ctrl.none_fit));
   assign open       = open_ff;

   always_comb begin
      last_end_in = last_end_ff;
      open_in     = open_ff;
      if (take) begin
         last_end_in = end_time;
      end
      if (ctrl.clear) begin
         open_in = 1'b0;
      end else if (take && first_free) begin
         open_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      last_end_ff <= last_end_in;
   end

endmodule

[design/interval_partition_assigner_top.sv]
// Top level of the interval partition assigner: resource row, bookkeeping, result register.
//
// The block assigns activities, presented in order of start time, to resources by the
// greedy earliest-start rule. Each request transaction carries an action in req_tuser
// (schedule or clear) and the start and end times in req_tdata. A row of RESOURCES
// identical cells holds one resource each; every open cell compares its recorded end
// time with the new start in the same cycle, and a claim signal passed from the newest
// cell down to the oldest picks the highest-index resource that fits. If none fits, the
// first unopened cell takes the activity and the resource count grows. An activity whose
// start lies below the previous in-order start is dropped with an out-of-order status;
// one that finds every resource busy is dropped with a full status. A clear closes all
// resources at once. Every request transaction yields exactly one response transaction.
// The block accepts one transaction per cycle: the cell row settles a decision
// combinationally and updates its state at the same edge, and the response register lets a
// new request enter while the previous response is taken, so the block only stalls when
// a response is held back by rsp_tready. The response appears in the cycle after acceptance.
// No clearing pass follows reset; the cell open flags reset directly.
`include "interval_partition_assigner_top_macros.svh"

module interval_partition_assigner_top
   import ipa_pkg::*;
#(
   parameter int RESOURCES = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // Bits from the lowest up: start_time[15:0], end_time[31:16].
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // Bits from the lowest up: action[0].
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // Bits from the lowest up: resource_index[3:0], opened_new[4], status[6:5],
   // resources_in_use[11:7], zero fill[15:12].
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   localparam int IDX_BITS = $clog2(RESOURCES);
   localparam int CNT_BITS = $clog2(RESOURCES + 1);

   logic                 accept;
   logic                 is_clear;
   logic                 in_order;
   logic [TIME_BITS-1:0] start_time;
   logic [TIME_BITS-1:0] end_time;
   cell_ctrl_type        ctrl;

   logic [RESOURCES:0]   claim;
   logic [RESOURCES-1:0] take_vec;
   logic [RESOURCES-1:0] open_vec;
   logic [IDX_BITS-1:0]  take_idx;
   logic                 full;

   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   logic [TIME_BITS-1:0] prev_start_ff;
   logic [TIME_BITS-1:0] prev_start_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [RSP_INDEX_BITS-1:0] rsp_index_ff;
   logic [RSP_INDEX_BITS-1:0] rsp_index_in;
   logic                      rsp_opened_ff;
   logic                      rsp_opened_in;
   status_type                rsp_status_ff;
   status_type                rsp_status_in;
   logic [RSP_COUNT_BITS-1:0] rsp_count_ff;
   logic [RSP_COUNT_BITS-1:0] rsp_count_in;

   // The response register frees the input side whenever it is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Times use the low TIME_BITS bits of each field.
   assign start_time = TIME_BITS'(req_tdata[REQ_TIME_BITS-1:0]);
   assign end_time   = TIME_BITS'(req_tdata[REQ_TDATA_BITS-1:REQ_TIME_BITS]);
   assign is_clear   = (req_tuser == ACTION_CLEAR);
   assign in_order   = (start_time >= prev_start_ff);

   assign ctrl.schedule = accept && !is_clear && in_order;
   assign ctrl.clear    = accept && is_clear;
   assign ctrl.none_fit = !claim[0];

   // The claim travels from the newest cell down to the oldest.
   assign claim[RESOURCES] = 1'b0;

   for (genvar i = 0; i < RESOURCES; i++) begin : g_cell
      ipa_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .start_time (start_time),
         .end_time   (end_time),
         .claim_in   (claim[i+1]),
         .prev_open  ((i == 0) ? 1'b1 : open_vec[(i == 0) ? 0 : i-1]),
         .claim_out  (claim[i]),
         .take       (take_vec[i]),
         .open       (open_vec[i])
      );
   end

   assign full = open_vec[RESOURCES-1];

   // At most one cell takes the activity, so the index is an OR of the candidates.
   always_comb begin
      take_idx = '0;
      for (int i = 0; i < RESOURCES; i++) begin
         if (take_vec[i]) begin
            take_idx = take_idx | IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      prev_start_in = prev_start_ff;
      rsp_index_in  = '0;
      rsp_opened_in = 1'b0;
      rsp_status_in = STATUS_OK;
      if (ctrl.clear) begin
         count_in      = '0;
         prev_start_in = '0;
      end else if (accept && !in_order) begin
         rsp_status_in = STATUS_ORDER;
      end else if (ctrl.schedule) begin
         // Even a dropped activity moves the start mark, since the stream was in order.
         prev_start_in = start_time;
         if (!ctrl.none_fit) begin
            rsp_index_in = RSP_INDEX_BITS'(take_idx);
         end else if (!full) begin
            rsp_index_in  = RSP_INDEX_BITS'(take_idx);
            rsp_opened_in = 1'b1;
            count_in      = CNT_BITS'(count_ff + 1'b1);
         end else begin
            rsp_status_in = STATUS_FULL;
         end
      end
      rsp_count_in = RSP_COUNT_BITS'(count_in);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         prev_start_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         prev_start_ff <= prev_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // The payload loads only with an accepted transaction, so a held response stays put.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_index_ff  <= rsp_index_in;
         rsp_opened_ff <= rsp_opened_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      {(RSP_TDATA_BITS - RSP_COUNT_BITS - RSP_STATUS_BITS - 1 - RSP_INDEX_BITS){1'b0}},
      rsp_count_ff,
      rsp_status_ff,
      rsp_opened_ff,
      rsp_index_ff
   };

   // A single winner in the row, and open cells always form a block counted by count_ff.
   `IPA_ASSERT(a_single_take, clock, reset, $onehot0(take_vec))
   `IPA_ASSERT(a_count_matches_row, clock, reset, count_ff == $countones(open_vec))
   `IPA_ASSERT_NEXT(a_order_drop_keeps_state, clock, reset,
      accept && !is_clear && !in_order, $stable(count_ff) && $stable(prev_start_ff))
   `IPA_ASSERT_NEXT(a_open_reported, clock, reset,
      ctrl.schedule && ctrl.none_fit && !full, rsp_tvalid && rsp_tdata[RSP_INDEX_BITS])

endmodule
